>>> sv/lens_undistort_source_map_defines.svh
// Assertion macros used by the checker.
`ifndef LENS_UNDISTORT_SOURCE_MAP_DEFINES_SVH
`define LENS_UNDISTORT_SOURCE_MAP_DEFINES_SVH

// same-cycle implication
`define LUS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lus assertion failed");

// next-cycle implication
`define LUS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lus assertion failed");

`endif

>>> sv/lus_pkg.sv
package lus_pkg;

	localparam int COORD_W = 10;
	localparam int COEF_W = 23;
	localparam int GEOM_W = 19;
	localparam int FRAME_WIDTH = 1024;
	localparam int FRAME_HEIGHT = 1024;

	// normalized coordinate, Q.20, range [-2^23, 2^23]
	localparam int NORM_W = 25;
	localparam int DIV_STEPS = 25;
	localparam int DIV_LAT = DIV_STEPS + 2;
	localparam int POST_LAT = 9;
	localparam int LAT = DIV_LAT + POST_LAT;

	typedef enum logic [2:0] {
		REG_K1 = 3'd0,
		REG_K2 = 3'd1,
		REG_P1 = 3'd2,
		REG_P2 = 3'd3,
		REG_FX = 3'd4,
		REG_FY = 3'd5,
		REG_CX = 3'd6,
		REG_CY = 3'd7
	} reg_idx_t;

	localparam logic signed [COEF_W-1:0] K1_RST = -23'sd297175;
	localparam logic signed [COEF_W-1:0] K2_RST = 23'sd77552;
	localparam logic signed [COEF_W-1:0] P1_RST = 23'sd203;
	localparam logic signed [COEF_W-1:0] P2_RST = 23'sd18;
	localparam logic [GEOM_W-1:0] FX_RST = 19'd117415;
	localparam logic [GEOM_W-1:0] FY_RST = 19'd117068;
	localparam logic [GEOM_W-1:0] CX_RST = 19'd94007;
	localparam logic [GEOM_W-1:0] CY_RST = 19'd63584;

endpackage

>>> sv/lus_ifs.sv
interface lus_pix_if import lus_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;

	modport source(output valid, output out_col, output out_row, input ready);
	modport sink(input valid, input out_col, input out_row, output ready);
endinterface

interface lus_src_if import lus_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] src_col;
	logic [COORD_W-1:0] src_row;
	logic inside_res;

	modport source(output valid, output src_col, output src_row, output inside_res,
		input ready);
	modport sink(input valid, input src_col, input src_row, input inside_res,
		output ready);
endinterface

>>> sv/lus_div.sv
// Pipelined restoring divider: (pix*256 - centre) * 2^20 / focal, truncated, saturated.
module lus_div import lus_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [COORD_W-1:0]       pix,
	input  logic [GEOM_W-1:0]        centre,
	input  logic [GEOM_W-1:0]        focal,
	output logic signed [NORM_W-1:0] quo
);

	logic [GEOM_W-1:0] fz;
	logic signed [20:0] dx;
	logic [19:0] mag;

	logic [19:0] rem_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s [0:DIV_STEPS];
	logic [4:0] low_s [0:4];
	logic neg_s [0:DIV_STEPS];
	logic sat_s [0:DIV_STEPS];

	logic [19:0] t_w [1:DIV_STEPS];
	logic ge_w [1:DIV_STEPS];

	logic over;
	logic [23:0] magsat;

	assign fz = (focal == '0) ? 19'd1 : focal;
	assign dx = $signed({3'b0, pix, 8'b0}) - $signed({2'b0, centre});
	assign mag = dx[20] ? 20'(-dx) : dx[19:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {5'b0, mag[19:5]};
			q_s[0] <= '0;
			low_s[0] <= mag[4:0];
			neg_s[0] <= dx[20];
			sat_s[0] <= ({4'b0, mag[19:5]} >= fz);
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		localparam int B = DIV_STEPS - j;
		if (B >= 20) begin : g_nb
			assign t_w[j] = {rem_s[j-1][18:0], low_s[j-1][B-20]};
		end else begin : g_zero
			assign t_w[j] = {rem_s[j-1][18:0], 1'b0};
		end
		assign ge_w[j] = (t_w[j] >= {1'b0, fz});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge_w[j] ? (t_w[j] - {1'b0, fz}) : t_w[j];
				q_s[j] <= q_s[j-1] | (DIV_STEPS'(ge_w[j]) << B);
				neg_s[j] <= neg_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end

		if (j <= 4) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[j] <= low_s[j-1];
				end
			end
		end
	end

	assign over = sat_s[DIV_STEPS] || (q_s[DIV_STEPS] > 25'd8388608);
	assign magsat = over ? 24'h800000 : q_s[DIV_STEPS][23:0];

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[DIV_STEPS] ? -$signed({1'b0, magsat}) : $signed({1'b0, magsat});
		end
	end

endmodule

>>> sv/lens_undistort_source_map.sv
// Brown-Conrady source map: for each output pixel transfer, gives the truncated source pixel
// in the distorted frame and an inside flag (zero coordinates when outside). Fully pipelined:
// one coordinate per clock while no result is stalled at the output. The depth is set by the
// per-axis normalizing divider, 27 stages (an input register, one quotient bit per stage over
// 25 stages, an output register), followed by a nine-stage multiply chain. The whole pipeline
// holds while a result waits; the user must write registers through the cfg port only while
// no item is in flight, as the block itself does not enforce it.
module lens_undistort_source_map import lus_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [COEF_W-1:0]  cfg_data,
	lus_pix_if.sink            pix,
	lus_src_if.source          src
);

	logic signed [COEF_W-1:0] k1_q, k2_q, p1_q, p2_q;
	logic [GEOM_W-1:0] fx_q, fy_q, cx_q, cy_q;
	logic [GEOM_W-1:0] fzx, fzy;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [NORM_W-1:0] xq, yq;

	logic signed [NORM_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic signed [49:0] xx_s1, yy_s1, xy_s1;
	logic [26:0] x2_s2, y2_s2;
	logic [27:0] r2_s2;
	logic signed [27:0] xy_s2;
	logic [55:0] r4p_s3;
	logic signed [51:0] k1r2_s3;
	logic signed [52:0] tpx_s3, tpy_s3;
	logic signed [50:0] pxy1_s3, pxy2_s3;
	logic [28:0] tx_w, ty_w;
	logic signed [59:0] k2r4_s4;
	logic signed [31:0] k1s_s4;
	logic signed [33:0] tgx_s4, tgy_s4, tgx_s5, tgy_s5, tgx_s6, tgy_s6;
	logic signed [40:0] rad_w;
	logic signed [37:0] rad_s5;
	logic signed [45:0] xl_s6, yl_s6;
	logic signed [42:0] xh_s6, yh_s6;
	logic signed [42:0] xd_s7, yd_s7;
	logic signed [62:0] up_s8, vp_s8;
	logic signed [43:0] ud_w, vd_w;
	logic inside_w;
	logic [COORD_W-1:0] col_s9, row_s9;
	logic inside_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= K1_RST;
			k2_q <= K2_RST;
			p1_q <= P1_RST;
			p2_q <= P2_RST;
			fx_q <= FX_RST;
			fy_q <= FY_RST;
			cx_q <= CX_RST;
			cy_q <= CY_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_K1: k1_q <= cfg_data;
				REG_K2: k2_q <= cfg_data;
				REG_P1: p1_q <= cfg_data;
				REG_P2: p2_q <= cfg_data;
				REG_FX: fx_q <= cfg_data[GEOM_W-1:0];
				REG_FY: fy_q <= cfg_data[GEOM_W-1:0];
				REG_CX: cx_q <= cfg_data[GEOM_W-1:0];
				REG_CY: cy_q <= cfg_data[GEOM_W-1:0];
			endcase
		end
	end

	assign fzx = (fx_q == '0) ? 19'd1 : fx_q;
	assign fzy = (fy_q == '0) ? 19'd1 : fy_q;

	assign en = !vld_q[LAT-1] || src.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pix.valid};
		end
	end

	lus_div u_div_x (
		.clk(clk), .en(en), .pix(pix.out_col), .centre(cx_q), .focal(fx_q), .quo(xq)
	);
	lus_div u_div_y (
		.clk(clk), .en(en), .pix(pix.out_row), .centre(cy_q), .focal(fy_q), .quo(yq)
	);

	assign tx_w = 29'(r2_s2) + 29'({x2_s2, 1'b0});
	assign ty_w = 29'(r2_s2) + 29'({y2_s2, 1'b0});
	assign rad_w = 41'sd1048576 + 41'(k1s_s4) + 41'(k2r4_s4 >>> 20);
	assign ud_w = 44'(up_s8 >>> 20) + $signed({25'b0, cx_q});
	assign vd_w = 44'(vp_s8 >>> 20) + $signed({25'b0, cy_q});
	assign inside_w = !ud_w[43] && !vd_w[43]
		&& (ud_w < 44'sd262144 * FRAME_WIDTH / 1024)
		&& (vd_w < 44'sd262144 * FRAME_HEIGHT / 1024);

	always_ff @(posedge clk) begin
		if (en) begin
			// squares and cross product
			x_s1 <= xq;
			y_s1 <= yq;
			xx_s1 <= xq * xq;
			yy_s1 <= yq * yq;
			xy_s1 <= xq * yq;
			// x2, y2, r2, xy
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			x2_s2 <= 27'(xx_s1 >>> 20);
			y2_s2 <= 27'(yy_s1 >>> 20);
			r2_s2 <= 28'((xx_s1 + yy_s1) >>> 20);
			xy_s2 <= 28'(xy_s1 >>> 20);
			// r4 product, k1 and tangential products
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			r4p_s3 <= r2_s2 * r2_s2;
			k1r2_s3 <= k1_q * $signed({1'b0, r2_s2});
			tpx_s3 <= p2_q * $signed({1'b0, tx_w});
			tpy_s3 <= p1_q * $signed({1'b0, ty_w});
			pxy1_s3 <= p1_q * xy_s2;
			pxy2_s3 <= p2_q * xy_s2;
			// k2 term, tangential sums
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			k2r4_s4 <= k2_q * $signed({1'b0, r4p_s3[55:20]});
			k1s_s4 <= 32'(k1r2_s3 >>> 20);
			tgx_s4 <= 34'(pxy1_s3 >>> 19) + 34'(tpx_s3 >>> 20);
			tgy_s4 <= 34'(pxy2_s3 >>> 19) + 34'(tpy_s3 >>> 20);
			// radial factor
			x_s5 <= x_s4;
			y_s5 <= y_s4;
			tgx_s5 <= tgx_s4;
			tgy_s5 <= tgy_s4;
			rad_s5 <= rad_w[37:0];
			// x*rad split in two partial products
			xl_s6 <= x_s5 * $signed({1'b0, rad_s5[19:0]});
			yl_s6 <= y_s5 * $signed({1'b0, rad_s5[19:0]});
			xh_s6 <= x_s5 * $signed(rad_s5[37:20]);
			yh_s6 <= y_s5 * $signed(rad_s5[37:20]);
			tgx_s6 <= tgx_s5;
			tgy_s6 <= tgy_s5;
			// distorted normalized point
			xd_s7 <= xh_s6 + 43'(xl_s6 >>> 20) + 43'(tgx_s6);
			yd_s7 <= yh_s6 + 43'(yl_s6 >>> 20) + 43'(tgy_s6);
			// back to pixels
			up_s8 <= xd_s7 * $signed({1'b0, fzx});
			vp_s8 <= yd_s7 * $signed({1'b0, fzy});
			// frame test, output register
			col_s9 <= inside_w ? ud_w[8 +: COORD_W] : '0;
			row_s9 <= inside_w ? vd_w[8 +: COORD_W] : '0;
			inside_s9 <= inside_w;
		end
	end

	assign src.valid = vld_q[LAT-1];
	assign src.src_col = col_s9;
	assign src.src_row = row_s9;
	assign src.inside_res = inside_s9;

endmodule

>>> sv/lus_checker.sv
`include "lens_undistort_source_map_defines.svh"

module lus_checker import lus_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COORD_W-1:0] src_col,
	input logic [COORD_W-1:0] src_row,
	input logic               inside_res
);

	`LUS_ASSERT_IMP(a_outside_zero, clk, arst_n, out_valid && !inside_res, src_col == '0 && src_row == '0)
	`LUS_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`LUS_ASSERT_IMP(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready)
	`LUS_ASSERT_NXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(src_col) && $stable(src_row) && $stable(inside_res))

endmodule

bind lens_undistort_source_map lus_checker u_lus_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pix.ready),
	.out_valid(src.valid),
	.out_ready(src.ready),
	.src_col(src.src_col),
	.src_row(src.src_row),
	.inside_res(src.inside_res)
);
